### hw/rtl/sdes_pkg.sv
package sdes_pkg;

    localparam int unsigned KeyWidth = 10;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned HalfWidth = 4;
    localparam int unsigned SubkeyWidth = 8;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth = 10;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CfgIdxCipherKey = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgIdxDecryptMode = 2'd1;

    typedef logic [ByteWidth-1:0] byte_t;
    typedef logic [HalfWidth-1:0] half_t;
    typedef logic [SubkeyWidth-1:0] subkey_t;
    typedef logic [KeyWidth-1:0] key_t;

    // Subkeys in the order the two rounds use them.
    typedef struct packed {
        subkey_t first;
        subkey_t second;
    } subkeys_t;

    // S-boxes, indexed by {row, column}.
    localparam logic [1:0] SBOX0 [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] SBOX1 [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic key_t perm_p10(key_t k);
        return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
    endfunction

    function automatic subkey_t perm_p8(key_t k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic byte_t perm_ip(byte_t x);
        return {x[6], x[2], x[5], x[7], x[4], x[0], x[3], x[1]};
    endfunction

    function automatic byte_t perm_ip_inv(byte_t x);
        return {x[4], x[7], x[5], x[3], x[1], x[6], x[0], x[2]};
    endfunction

    function automatic subkey_t expand_ep(half_t r);
        return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
    endfunction

    function automatic half_t perm_p4(half_t s);
        return {s[2], s[0], s[1], s[3]};
    endfunction

    // Each five-bit half rotates left by one.
    function automatic key_t rotate_by_one(key_t x);
        return {x[8:5], x[9], x[3:0], x[4]};
    endfunction

    // Each five-bit half rotates left by two.
    function automatic key_t rotate_by_two(key_t x);
        return {x[7:5], x[9:8], x[2:0], x[4:3]};
    endfunction

    function automatic subkeys_t key_schedule(key_t key, logic decrypt);
        key_t p;
        key_t a;
        key_t b;
        subkey_t k1;
        subkey_t k2;
        subkeys_t ks;
        p = perm_p10(key);
        a = rotate_by_one(p);
        b = rotate_by_two(a);
        k1 = perm_p8(a);
        k2 = perm_p8(b);
        if (decrypt)
        begin
            ks.first = k2;
            ks.second = k1;
        end
        else
        begin
            ks.first = k1;
            ks.second = k2;
        end
        return ks;
    endfunction

    // Round function F: expansion, subkey mix, S-boxes and P4.
    function automatic half_t round_f(half_t r, subkey_t sk);
        subkey_t x;
        half_t a;
        half_t b;
        half_t s;
        x = expand_ep(r) ^ sk;
        a = x[7:4];
        b = x[3:0];
        s = {SBOX0[{a[3], a[0], a[2], a[1]}], SBOX1[{b[3], b[0], b[2], b[1]}]};
        return perm_p4(s);
    endfunction

endpackage

### hw/rtl/sdes_data_if.sv
interface sdes_data_if;
    logic valid;
    logic ready;
    sdes_pkg::byte_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

### hw/rtl/sdes_result_if.sv
interface sdes_result_if;
    logic valid;
    logic ready;
    sdes_pkg::byte_t result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink (input valid, input result_byte, output ready);
endinterface

### hw/rtl/sdes_cfg_if.sv
interface sdes_cfg_if;
    logic valid;
    logic ready;
    logic [sdes_pkg::CfgIndexWidth-1:0] reg_index;
    logic [sdes_pkg::CfgDataWidth-1:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

### hw/rtl/sdes_byte_cipher_top.sv
// S-DES byte cipher.
// data_chan takes one byte per request; result_chan returns the enciphered or
// deciphered byte for each request, in order, one result for every request.
// cfg_chan writes the registers: index 0 is the ten-bit key (first key bit is
// the MSB), index 1 selects decryption in bit 0. Writes to other indexes are
// dropped. The user must change configuration only while no request is in
// flight; the block itself does not enforce it. A write reaches the key and
// mode registers, and the subkey register follows them.
// The datapath is three register stages: initial permutation, the first round
// with the half swap, and the second round with the inverse permutation. A
// request passes through them in that order. While result_chan is not stalled,
// a new request can be taken at every edge, so throughput is one byte per cycle.
// Reset empties all stages and sets the key and mode registers to zero.
// When the receiver holds result_chan.ready low, the result stays on the port
// and the stages behind it keep filling; data_chan.ready falls only when all
// three stages hold requests. No request is lost or repeated by a stall.
module sdes_byte_cipher_top (
    input  logic            clk,
    input  logic            rst_n,
    sdes_data_if.sink       data_chan,
    sdes_result_if.source   result_chan,
    sdes_cfg_if.sink        cfg_chan
);

    sdes_pkg::subkeys_t subkeys;

    // Stage handshakes and payloads.
    logic            s1_valid;
    logic            s1_ready;
    sdes_pkg::byte_t s1_data;
    logic            s2_valid;
    logic            s2_ready;
    sdes_pkg::byte_t s2_data;

    sdes_pkg::byte_t ip_byte;
    sdes_pkg::byte_t round1_byte;
    sdes_pkg::byte_t round2_byte;
    sdes_pkg::half_t r1_left;
    sdes_pkg::half_t r1_right;
    sdes_pkg::half_t r2_left;
    sdes_pkg::half_t r2_right;

    sdes_key_sched u_key_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_chan),
        .subkeys (subkeys)
    );

    // Stage one: initial permutation.
    assign ip_byte = sdes_pkg::perm_ip(data_chan.data_byte);

    sdes_pipe_stage #(.WIDTH(sdes_pkg::ByteWidth)) u_stage_ip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (data_chan.valid),
        .in_ready  (data_chan.ready),
        .in_data   (ip_byte),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage two: first round, then the halves swap.
    assign r1_left = s1_data[7:4];
    assign r1_right = s1_data[3:0];
    assign round1_byte = {r1_right, r1_left ^ sdes_pkg::round_f(r1_right, subkeys.first)};

    sdes_pipe_stage #(.WIDTH(sdes_pkg::ByteWidth)) u_stage_round1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (round1_byte),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage three: second round and the inverse permutation.
    assign r2_left = s2_data[7:4];
    assign r2_right = s2_data[3:0];
    assign round2_byte = sdes_pkg::perm_ip_inv(
        {r2_left ^ sdes_pkg::round_f(r2_right, subkeys.second), r2_right});

    sdes_pipe_stage #(.WIDTH(sdes_pkg::ByteWidth)) u_stage_round2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (round2_byte),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .out_data  (result_chan.result_byte)
    );

endmodule

### hw/rtl/sdes_key_sched.sv
module sdes_key_sched (
    input  logic               clk,
    input  logic               rst_n,
    sdes_cfg_if.sink           cfg,
    output sdes_pkg::subkeys_t subkeys
);

    sdes_pkg::key_t     cipher_key_reg;
    sdes_pkg::key_t     cipher_key_next;
    logic               decrypt_mode_reg;
    logic               decrypt_mode_next;
    sdes_pkg::subkeys_t subkeys_reg;

    // Register writes are always taken.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cipher_key_next = cipher_key_reg;
        decrypt_mode_next = decrypt_mode_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                sdes_pkg::CfgIdxCipherKey:
                begin
                    cipher_key_next = cfg.write_data;
                end
                sdes_pkg::CfgIdxDecryptMode:
                begin
                    decrypt_mode_next = cfg.write_data[0];
                end
                default:
                begin
                    cipher_key_next = cipher_key_reg;
                end
            endcase
        end
    end

    // Subkeys are registered, derived from the stored key and mode registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
            decrypt_mode_reg <= 1'b0;
            subkeys_reg <= sdes_pkg::key_schedule('0, 1'b0);
        end
        else
        begin
            cipher_key_reg <= cipher_key_next;
            decrypt_mode_reg <= decrypt_mode_next;
            subkeys_reg <= sdes_pkg::key_schedule(cipher_key_reg, decrypt_mode_reg);
        end
    end

    assign subkeys = subkeys_reg;

endmodule

### hw/rtl/sdes_pipe_stage.sv
module sdes_pipe_stage #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // The stage loads whenever it is empty or its content leaves this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

### hw/rtl/sdes_checker.sv
module sdes_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !out_fire)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_fire && !in_fire)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A waiting result is held until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // No result appears without a request in flight.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without an outstanding request");

    // At most three requests are in flight, one per stage.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more requests in flight than stages");

    // An empty output stage never blocks the input.
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

endmodule

bind sdes_byte_cipher_top sdes_checker u_sdes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (data_chan.valid),
    .in_ready  (data_chan.ready),
    .out_valid (result_chan.valid),
    .out_ready (result_chan.ready)
);
